@@ rtl/tli_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types, constants and the operation sequence of the interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_DATA_WIDTH  = 48;
  localparam int DEF_FRAC_BITS   = 32;

  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int CNT_RESET = 4;
  localparam int MUL_CHUNK = 16;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic [4:0] slot_t;
  typedef logic [5:0] upc_t;

  // register file slots
  localparam slot_t SL_X0  = 5'd0;
  localparam slot_t SL_X1  = 5'd1;
  localparam slot_t SL_X2  = 5'd2;
  localparam slot_t SL_X3  = 5'd3;
  localparam slot_t SL_F0  = 5'd4;
  localparam slot_t SL_F1  = 5'd5;
  localparam slot_t SL_F2  = 5'd6;
  localparam slot_t SL_F3  = 5'd7;
  localparam slot_t SL_XV  = 5'd8;
  localparam slot_t SL_D10 = 5'd9;
  localparam slot_t SL_D21 = 5'd10;
  localparam slot_t SL_D32 = 5'd11;
  localparam slot_t SL_D20 = 5'd12;
  localparam slot_t SL_D31 = 5'd13;
  localparam slot_t SL_D30 = 5'd14;
  localparam slot_t SL_C1  = 5'd15;
  localparam slot_t SL_C2  = 5'd16;
  localparam slot_t SL_C3  = 5'd17;
  localparam slot_t SL_CC1 = 5'd18;
  localparam slot_t SL_CC2 = 5'd19;
  localparam slot_t SL_CCC = 5'd20;
  localparam slot_t SL_T   = 5'd21;
  localparam slot_t SL_T1  = 5'd22;
  localparam slot_t SL_T2  = 5'd23;
  localparam slot_t SL_VAL = 5'd24;
  localparam slot_t SL_SLP = 5'd25;
  localparam slot_t SL_CRV = 5'd26;

  localparam upc_t UPC_FCHK = 6'd6;
  localparam upc_t UPC_LAST = 6'd45;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} alu_op_t;
  typedef enum logic [1:0] {SRC_ALU, SRC_X, SRC_F, SRC_XV} rf_src_t;

  typedef enum logic [3:0] {
    S_IDLE, S_XV, S_FIRST, S_LAST, S_BADDR, S_BCMP, S_CLAMP,
    S_PADDR, S_PX, S_PF, S_ORD, S_OEX, S_OWT, S_DONE
  } ctrl_st_t;

  typedef enum logic [1:0] {U_IDLE, U_RUN, U_FIN} unit_st_t;

  typedef struct packed {
    alu_op_t op;
    slot_t   d;
    slot_t   a;
    slot_t   b;
    logic    chk;
  } uop_t;

  typedef struct packed {
    logic    cap_in;
    logic    wr_tbl;
    logic    cap_first;
    logic    rf_we;
    rf_src_t rf_src;
    slot_t   rf_wa;
    slot_t   rf_ra;
    slot_t   rf_rb;
    alu_op_t alu_op;
    logic    alu_start;
    logic    chk;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic xv_le_first;
    logic xv_ge_first;
    logic xv_le_rd;
    logic xv_ge_rd;
    logic rd_ge_first;
    logic unit_done;
    logic fault;
  } dp_sts_t;

  function automatic uop_t mk(alu_op_t op, slot_t d, slot_t a, slot_t b, logic chk);
    uop_t u;
    u.op  = op;
    u.d   = d;
    u.a   = a;
    u.b   = b;
    u.chk = chk;
    return u;
  endfunction

  // divided differences, then value, slope and curvature
  function automatic uop_t uop_at(upc_t pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(OP_SUB, SL_D10, SL_X1, SL_X0, 1'b1);
      6'd1:  u = mk(OP_SUB, SL_D21, SL_X2, SL_X1, 1'b1);
      6'd2:  u = mk(OP_SUB, SL_D32, SL_X3, SL_X2, 1'b1);
      6'd3:  u = mk(OP_SUB, SL_D20, SL_X2, SL_X0, 1'b1);
      6'd4:  u = mk(OP_SUB, SL_D31, SL_X3, SL_X1, 1'b1);
      6'd5:  u = mk(OP_SUB, SL_D30, SL_X3, SL_X0, 1'b1);
      6'd6:  u = mk(OP_SUB, SL_T1, SL_F1, SL_F0, 1'b0);
      6'd7:  u = mk(OP_DIV, SL_C1, SL_T1, SL_D10, 1'b0);
      6'd8:  u = mk(OP_SUB, SL_T1, SL_F2, SL_F1, 1'b0);
      6'd9:  u = mk(OP_DIV, SL_C2, SL_T1, SL_D21, 1'b0);
      6'd10: u = mk(OP_SUB, SL_T1, SL_F3, SL_F2, 1'b0);
      6'd11: u = mk(OP_DIV, SL_C3, SL_T1, SL_D32, 1'b0);
      6'd12: u = mk(OP_SUB, SL_T1, SL_C2, SL_C1, 1'b0);
      6'd13: u = mk(OP_DIV, SL_CC1, SL_T1, SL_D20, 1'b0);
      6'd14: u = mk(OP_SUB, SL_T1, SL_C3, SL_C2, 1'b0);
      6'd15: u = mk(OP_DIV, SL_CC2, SL_T1, SL_D31, 1'b0);
      6'd16: u = mk(OP_SUB, SL_T1, SL_CC2, SL_CC1, 1'b0);
      6'd17: u = mk(OP_DIV, SL_CCC, SL_T1, SL_D30, 1'b0);
      6'd18: u = mk(OP_SUB, SL_T1, SL_XV, SL_X2, 1'b0);
      6'd19: u = mk(OP_MUL, SL_T1, SL_CCC, SL_T1, 1'b0);
      6'd20: u = mk(OP_ADD, SL_T, SL_CC1, SL_T1, 1'b0);
      6'd21: u = mk(OP_SUB, SL_T1, SL_XV, SL_X1, 1'b0);
      6'd22: u = mk(OP_MUL, SL_T1, SL_T1, SL_T, 1'b0);
      6'd23: u = mk(OP_ADD, SL_T1, SL_C1, SL_T1, 1'b0);
      6'd24: u = mk(OP_SUB, SL_T2, SL_XV, SL_X0, 1'b0);
      6'd25: u = mk(OP_MUL, SL_T1, SL_T2, SL_T1, 1'b0);
      6'd26: u = mk(OP_ADD, SL_VAL, SL_F0, SL_T1, 1'b0);
      6'd27: u = mk(OP_ADD, SL_T1, SL_X1, SL_X2, 1'b0);
      6'd28: u = mk(OP_SUB, SL_T1, SL_T1, SL_XV, 1'b0);
      6'd29: u = mk(OP_SUB, SL_T1, SL_T1, SL_XV, 1'b0);
      6'd30: u = mk(OP_MUL, SL_T1, SL_CCC, SL_T1, 1'b0);
      6'd31: u = mk(OP_SUB, SL_T1, SL_CC1, SL_T1, 1'b0);
      6'd32: u = mk(OP_SUB, SL_T2, SL_X0, SL_XV, 1'b0);
      6'd33: u = mk(OP_MUL, SL_T1, SL_T1, SL_T2, 1'b0);
      6'd34: u = mk(OP_SUB, SL_SLP, SL_C1, SL_T1, 1'b0);
      6'd35: u = mk(OP_SUB, SL_T1, SL_XV, SL_X1, 1'b0);
      6'd36: u = mk(OP_MUL, SL_T1, SL_T1, SL_T, 1'b0);
      6'd37: u = mk(OP_ADD, SL_SLP, SL_SLP, SL_T1, 1'b0);
      6'd38: u = mk(OP_ADD, SL_T1, SL_X1, SL_X0, 1'b0);
      6'd39: u = mk(OP_ADD, SL_T1, SL_T1, SL_X2, 1'b0);
      6'd40: u = mk(OP_SUB, SL_T1, SL_T1, SL_XV, 1'b0);
      6'd41: u = mk(OP_SUB, SL_T1, SL_T1, SL_XV, 1'b0);
      6'd42: u = mk(OP_SUB, SL_T1, SL_T1, SL_XV, 1'b0);
      6'd43: u = mk(OP_MUL, SL_T1, SL_CCC, SL_T1, 1'b0);
      6'd44: u = mk(OP_SUB, SL_CRV, SL_CC1, SL_T1, 1'b0);
      6'd45: u = mk(OP_ADD, SL_CRV, SL_CRV, SL_CRV, 1'b0);
      default: u = mk(OP_ADD, SL_T2, SL_T2, SL_T2, 1'b0);
    endcase
    return u;
  endfunction

endpackage

@@ rtl/tli_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_if
// Valid/ready channels of the interpolator: query/load, result, config.
// ----------------------------------------------------------------------------
interface tli_in_if #(parameter int DATA_WIDTH = tli_pkg::DEF_DATA_WIDTH);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [tli_pkg::IDX_W-1:0]     entry_index;
  logic signed [DATA_WIDTH-1:0]  entry_abscissa;
  logic signed [DATA_WIDTH-1:0]  entry_ordinate;
  logic signed [DATA_WIDTH-1:0]  query_point;

  modport source (output valid, action, entry_index, entry_abscissa, entry_ordinate,
                  query_point, input ready);
  modport sink (input valid, action, entry_index, entry_abscissa, entry_ordinate,
                query_point, output ready);
endinterface

interface tli_out_if #(parameter int DATA_WIDTH = tli_pkg::DEF_DATA_WIDTH);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  value;
  logic signed [DATA_WIDTH-1:0]  slope;
  logic signed [DATA_WIDTH-1:0]  curvature;
  logic                          divide_fault;

  modport source (output valid, value, slope, curvature, divide_fault, input ready);
  modport sink (input valid, value, slope, curvature, divide_fault, output ready);
endinterface

interface tli_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [tli_pkg::CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/tli_arith.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_arith
// Shared multi-cycle fixed point multiplier and restoring divider with
// saturation of the signed result.
// ----------------------------------------------------------------------------
module tli_arith #(
  parameter int DATA_WIDTH = tli_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = tli_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         is_div,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] result
);
  import tli_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int NCH  = (DW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int MCW  = NCH * MUL_CHUNK;
  localparam int ACW  = DW + MCW;
  localparam int NW   = DW + FRAC_BITS;
  localparam int SW   = (ACW > NW) ? ACW : NW;
  localparam int CNTW = $clog2(NW + 1);

  unit_st_t st_r, st_nxt;
  logic            div_r, div_nxt;
  logic            neg_r, neg_nxt;
  logic [DW-1:0]   ma_r, ma_nxt;
  logic [MCW-1:0]  mb_r, mb_nxt;
  logic [ACW-1:0]  acc_r, acc_nxt;
  logic [NW-1:0]   num_r, num_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [NW-1:0]   q_r, q_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic signed [DW-1:0] res_r, res_nxt;
  logic            done_r, done_nxt;

  logic [DW-1:0]            abs_a, abs_b;
  logic [DW+MUL_CHUNK-1:0]  prod;
  logic [DW:0]              trial, trial_sub;
  logic                     ge;
  logic [SW-1:0]            mag_sel, lim;
  logic signed [DW-1:0]     sat_val;

  assign abs_a = a[DW-1] ? (~a + 1'b1) : a;
  assign abs_b = b[DW-1] ? (~b + 1'b1) : b;

  assign prod      = ma_r * mb_r[MCW-1 -: MUL_CHUNK];
  assign trial     = {rem_r, num_r[NW-1]};
  assign trial_sub = trial - {1'b0, mb_r[DW-1:0]};
  assign ge        = (trial >= {1'b0, mb_r[DW-1:0]});

  assign mag_sel = div_r ? SW'(q_r) : SW'(acc_r >> FRAC_BITS);
  assign lim     = SW'(1) << (DW - 1);

  always_comb begin
    if (mag_sel >= lim) begin
      sat_val = neg_r ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else if (neg_r) begin
      sat_val = ~mag_sel[DW-1:0] + 1'b1;
    end else begin
      sat_val = mag_sel[DW-1:0];
    end
  end

  always_comb begin
    st_nxt   = st_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    acc_nxt  = acc_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    unique case (st_r)
      U_IDLE: begin
        if (start) begin
          div_nxt = is_div;
          neg_nxt = a[DW-1] ^ b[DW-1];
          ma_nxt  = abs_a;
          mb_nxt  = MCW'(abs_b);
          acc_nxt = '0;
          num_nxt = NW'({abs_a, {FRAC_BITS{1'b0}}});
          rem_nxt = '0;
          q_nxt   = '0;
          cnt_nxt = '0;
          st_nxt  = U_RUN;
        end
      end
      U_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (div_r) begin
          num_nxt = num_r << 1;
          q_nxt   = {q_r[NW-2:0], ge};
          rem_nxt = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
          if (cnt_r == CNTW'(NW - 1)) st_nxt = U_FIN;
        end else begin
          // most significant chunk first, accumulator shifts up
          acc_nxt = (acc_r << MUL_CHUNK) + ACW'(prod);
          mb_nxt  = mb_r << MUL_CHUNK;
          if (cnt_r == CNTW'(NCH - 1)) st_nxt = U_FIN;
        end
      end
      U_FIN: begin
        res_nxt  = sat_val;
        done_nxt = 1'b1;
        st_nxt   = U_IDLE;
      end
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

@@ rtl/tli_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_datapath
// Sample tables, working register file, saturating add/sub, shared
// multiply/divide unit and the result register.
// ----------------------------------------------------------------------------
module tli_datapath #(
  parameter int TABLE_DEPTH = tli_pkg::DEF_TABLE_DEPTH,
  parameter int DATA_WIDTH  = tli_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS   = tli_pkg::DEF_FRAC_BITS,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tli_pkg::dp_cmd_t              cmd,
  input  logic [AW-1:0]                 tbl_addr,
  output tli_pkg::dp_sts_t              sts,
  input  logic [tli_pkg::IDX_W-1:0]     in_index,
  input  logic signed [DATA_WIDTH-1:0]  in_abscissa,
  input  logic signed [DATA_WIDTH-1:0]  in_ordinate,
  input  logic signed [DATA_WIDTH-1:0]  in_query,
  output logic signed [DATA_WIDTH-1:0]  out_value,
  output logic signed [DATA_WIDTH-1:0]  out_slope,
  output logic signed [DATA_WIDTH-1:0]  out_curvature,
  output logic                          out_fault
);
  import tli_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW-1:0] x_mem [TABLE_DEPTH];
  logic signed [DW-1:0] f_mem [TABLE_DEPTH];
  logic signed [DW-1:0] rf_mem [32];

  logic signed [DW-1:0] x_rd_r, f_rd_r, opa_r, opb_r;
  logic signed [DW-1:0] xv_r, first_r;
  logic signed [DW-1:0] val_r, slp_r, crv_r;
  logic signed [DW-1:0] out_value_r, out_slope_r, out_curv_r;
  logic                 out_fault_r;
  logic                 fault_r, fault_nxt;

  logic [AW-1:0]        waddr;
  logic                 wr_ok;
  logic [DW:0]          sum;
  logic signed [DW-1:0] addsub, wdata;
  logic                 unit_done;
  logic signed [DW-1:0] unit_res;

  assign waddr = AW'(in_index);
  assign wr_ok = cmd.wr_tbl && (32'(in_index) < TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      x_mem[waddr] <= in_abscissa;
      f_mem[waddr] <= in_ordinate;
    end
    x_rd_r <= x_mem[tbl_addr];
    f_rd_r <= f_mem[tbl_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rf_we) rf_mem[cmd.rf_wa] <= wdata;
    opa_r <= rf_mem[cmd.rf_ra];
    opb_r <= rf_mem[cmd.rf_rb];
  end

  always_comb begin
    if (cmd.alu_op == OP_SUB) begin
      sum = {opa_r[DW-1], opa_r} - {opb_r[DW-1], opb_r};
    end else begin
      sum = {opa_r[DW-1], opa_r} + {opb_r[DW-1], opb_r};
    end
    if (sum[DW] != sum[DW-1]) begin
      addsub = sum[DW] ? DMIN : DMAX;
    end else begin
      addsub = sum[DW-1:0];
    end
  end

  tli_arith #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.alu_start),
    .is_div (cmd.alu_op == OP_DIV),
    .a      (opa_r),
    .b      (opb_r),
    .done   (unit_done),
    .result (unit_res)
  );

  always_comb begin
    unique case (cmd.rf_src)
      SRC_ALU: wdata = (cmd.alu_op == OP_MUL || cmd.alu_op == OP_DIV) ? unit_res : addsub;
      SRC_X:   wdata = x_rd_r;
      SRC_F:   wdata = f_rd_r;
      SRC_XV:  wdata = xv_r;
      default: wdata = addsub;
    endcase
  end

  always_comb begin
    fault_nxt = fault_r;
    if (cmd.cap_in) begin
      fault_nxt = 1'b0;
    end else if (cmd.rf_we && cmd.chk && wdata == '0) begin
      fault_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= 1'b0;
    end else begin
      fault_r <= fault_nxt;
    end
    if (cmd.cap_in) xv_r <= in_query;
    if (cmd.cap_first) first_r <= x_rd_r;
    // keep the final writes of the three result slots
    if (cmd.rf_we && cmd.rf_wa == SL_VAL) val_r <= wdata;
    if (cmd.rf_we && cmd.rf_wa == SL_SLP) slp_r <= wdata;
    if (cmd.rf_we && cmd.rf_wa == SL_CRV) crv_r <= wdata;
    if (cmd.load_out) begin
      out_value_r <= fault_r ? DMAX : val_r;
      out_slope_r <= fault_r ? DMAX : slp_r;
      out_curv_r  <= fault_r ? DMAX : crv_r;
      out_fault_r <= fault_r;
    end
  end

  assign sts.xv_le_first = (xv_r <= first_r);
  assign sts.xv_ge_first = (xv_r >= first_r);
  assign sts.xv_le_rd    = (xv_r <= x_rd_r);
  assign sts.xv_ge_rd    = (xv_r >= x_rd_r);
  assign sts.rd_ge_first = (x_rd_r >= first_r);
  assign sts.unit_done   = unit_done;
  assign sts.fault       = fault_r;

  assign out_value     = out_value_r;
  assign out_slope     = out_slope_r;
  assign out_curvature = out_curv_r;
  assign out_fault     = out_fault_r;

endmodule

@@ rtl/tli_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_ctrl
// Sequencer: handshakes, bisection search, point fetch and the run of the
// operation sequence over the datapath.
// ----------------------------------------------------------------------------
module tli_ctrl #(
  parameter int TABLE_DEPTH = tli_pkg::DEF_TABLE_DEPTH,
  parameter int AW          = $clog2(TABLE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_action,
  output logic                      in_ready,
  input  logic                      cfg_valid,
  input  logic [tli_pkg::CNT_W-1:0] cfg_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output tli_pkg::dp_cmd_t          cmd,
  output logic [AW-1:0]             tbl_addr,
  input  tli_pkg::dp_sts_t          sts
);
  import tli_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  ctrl_st_t st_r, st_nxt;
  logic [CNT_W-1:0] pc_r, pc_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [CW-1:0]    lp_r, lp_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [CW-1:0]    mid_r, mid_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    base_r, base_nxt;
  logic [1:0]       k_r, k_nxt;
  upc_t             upc_r, upc_nxt;
  logic             asc_r, asc_nxt;
  logic             ovld_r, ovld_nxt;

  logic [CW-1:0] n_clamp, mid_c, i_c;
  logic [CW:0]   mid_sum;
  uop_t          u;

  always_comb begin
    if (pc_r < CNT_W'(4)) begin
      n_clamp = CW'(4);
    end else if (32'(pc_r) > TABLE_DEPTH) begin
      n_clamp = CW'(TABLE_DEPTH);
    end else begin
      n_clamp = CW'(pc_r);
    end
  end

  // lp is lo + 1, so mid = (hi + lo) >> 1
  assign mid_sum = {1'b0, hi_r} + {1'b0, lp_r} - 1'b1;
  assign mid_c   = mid_sum[CW:1];

  always_comb begin
    if (i_r < CW'(1)) begin
      i_c = CW'(1);
    end else if (i_r > n_r - CW'(3)) begin
      i_c = n_r - CW'(3);
    end else begin
      i_c = i_r;
    end
  end

  assign u = uop_at(upc_r);

  always_comb begin
    st_nxt   = st_r;
    pc_nxt   = pc_r;
    n_nxt    = n_r;
    lp_nxt   = lp_r;
    hi_nxt   = hi_r;
    mid_nxt  = mid_r;
    i_nxt    = i_r;
    base_nxt = base_r;
    k_nxt    = k_r;
    upc_nxt  = upc_r;
    asc_nxt  = asc_r;
    ovld_nxt = ovld_r;
    in_ready = 1'b0;
    tbl_addr = '0;
    cmd        = '0;
    cmd.rf_src = SRC_ALU;
    cmd.alu_op = u.op;
    cmd.rf_wa  = u.d;
    cmd.rf_ra  = u.a;
    cmd.rf_rb  = u.b;

    if (cfg_valid) pc_nxt = cfg_data;
    if (ovld_r && out_ready) ovld_nxt = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_LOAD) begin
            cmd.wr_tbl = 1'b1;
          end else begin
            cmd.cap_in = 1'b1;
            n_nxt      = n_clamp;
            st_nxt     = S_XV;
          end
        end
      end
      S_XV: begin
        cmd.rf_we  = 1'b1;
        cmd.rf_src = SRC_XV;
        cmd.rf_wa  = SL_XV;
        tbl_addr   = '0;
        st_nxt     = S_FIRST;
      end
      S_FIRST: begin
        cmd.cap_first = 1'b1;
        tbl_addr      = AW'(n_r - 1'b1);
        st_nxt        = S_LAST;
      end
      S_LAST: begin
        asc_nxt = sts.rd_ge_first;
        if (sts.rd_ge_first ? sts.xv_le_first : sts.xv_ge_first) begin
          i_nxt  = '0;
          st_nxt = S_CLAMP;
        end else if (sts.rd_ge_first ? sts.xv_ge_rd : sts.xv_le_rd) begin
          i_nxt  = n_r - 1'b1;
          st_nxt = S_CLAMP;
        end else begin
          lp_nxt = '0;
          hi_nxt = n_r;
          st_nxt = S_BADDR;
        end
      end
      S_BADDR: begin
        tbl_addr = AW'(mid_c);
        if (hi_r > lp_r) begin
          mid_nxt = mid_c;
          st_nxt  = S_BCMP;
        end else begin
          i_nxt  = (lp_r == '0) ? '0 : lp_r - 1'b1;
          st_nxt = S_CLAMP;
        end
      end
      S_BCMP: begin
        if (sts.xv_ge_rd == asc_r) begin
          lp_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
        st_nxt = S_BADDR;
      end
      S_CLAMP: begin
        base_nxt = i_c - 1'b1;
        k_nxt    = '0;
        st_nxt   = S_PADDR;
      end
      S_PADDR: begin
        tbl_addr = AW'(base_r + CW'(k_r));
        st_nxt   = S_PX;
      end
      S_PX: begin
        tbl_addr   = AW'(base_r + CW'(k_r));
        cmd.rf_we  = 1'b1;
        cmd.rf_src = SRC_X;
        cmd.rf_wa  = SL_X0 + slot_t'(k_r);
        st_nxt     = S_PF;
      end
      S_PF: begin
        tbl_addr   = AW'(base_r + CW'(k_r));
        cmd.rf_we  = 1'b1;
        cmd.rf_src = SRC_F;
        cmd.rf_wa  = SL_F0 + slot_t'(k_r);
        if (k_r == 2'd3) begin
          upc_nxt = '0;
          st_nxt  = S_ORD;
        end else begin
          k_nxt  = k_r + 1'b1;
          st_nxt = S_PADDR;
        end
      end
      S_ORD: begin
        // after the six differences a zero divisor ends the query
        if (upc_r == UPC_FCHK && sts.fault) begin
          st_nxt = S_DONE;
        end else begin
          st_nxt = S_OEX;
        end
      end
      S_OEX: begin
        if (u.op == OP_MUL || u.op == OP_DIV) begin
          cmd.alu_start = 1'b1;
          st_nxt        = S_OWT;
        end else begin
          cmd.rf_we = 1'b1;
          cmd.chk   = u.chk;
          if (upc_r == UPC_LAST) begin
            st_nxt = S_DONE;
          end else begin
            upc_nxt = upc_r + 1'b1;
            st_nxt  = S_ORD;
          end
        end
      end
      S_OWT: begin
        if (sts.unit_done) begin
          cmd.rf_we = 1'b1;
          if (upc_r == UPC_LAST) begin
            st_nxt = S_DONE;
          end else begin
            upc_nxt = upc_r + 1'b1;
            st_nxt  = S_ORD;
          end
        end
      end
      S_DONE: begin
        if (!ovld_r || out_ready) begin
          cmd.load_out = 1'b1;
          ovld_nxt     = 1'b1;
          st_nxt       = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      pc_r   <= CNT_W'(CNT_RESET);
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      pc_r   <= pc_nxt;
      ovld_r <= ovld_nxt;
    end
    n_r    <= n_nxt;
    lp_r   <= lp_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    i_r    <= i_nxt;
    base_r <= base_nxt;
    k_r    <= k_nxt;
    upc_r  <= upc_nxt;
    asc_r  <= asc_nxt;
  end

  assign out_valid = ovld_r;

endmodule

@@ rtl/table_lagrange_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_lagrange_interpolator
// Load beat: an index within the table depth is written to both sample tables at acceptance.
// Query beat: bisection search through the table read port, point fetch,
// then the operation sequence with add/sub, multiply and the shared divider
// for each of six divisions. One item in flight; a result waits in its
// register while the next beat is taken.
// Reset: synchronous, active low; point count returns to 4, tables keep data.
// ----------------------------------------------------------------------------
module table_lagrange_interpolator #(
  parameter int TABLE_DEPTH = tli_pkg::DEF_TABLE_DEPTH,
  parameter int DATA_WIDTH  = tli_pkg::DEF_DATA_WIDTH,
  parameter int FRAC_BITS   = tli_pkg::DEF_FRAC_BITS
) (
  input logic      clk,
  input logic      rst_n,
  tli_in_if.sink   in_ch,
  tli_out_if.source out_ch,
  tli_cfg_if.sink  cfg_ch
);
  import tli_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [AW-1:0] tbl_addr;

  assign cfg_ch.ready = 1'b1;

  tli_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .tbl_addr  (tbl_addr),
    .sts       (sts)
  );

  tli_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .AW          (AW)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .tbl_addr      (tbl_addr),
    .sts           (sts),
    .in_index      (in_ch.entry_index),
    .in_abscissa   (in_ch.entry_abscissa),
    .in_ordinate   (in_ch.entry_ordinate),
    .in_query      (in_ch.query_point),
    .out_value     (out_ch.value),
    .out_slope     (out_ch.slope),
    .out_curvature (out_ch.curvature),
    .out_fault     (out_ch.divide_fault)
  );

endmodule
